FILE: sv/ulamct_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and tables for the ULA memory contention timer.
// No dependencies; ulamct_lookup, the timer unit and the testbench import this package.
package ulamct_pkg;

    // Item kinds carried on the input tuser.
    localparam logic [1:0] ACT_MEM   = 2'd0;
    localparam logic [1:0] ACT_EARLY = 2'd1;
    localparam logic [1:0] ACT_LATE  = 2'd2;
    localparam logic [1:0] ACT_LOAD  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_LINE_TSTATES  = 3'd0;
    localparam logic [2:0] REG_LEFT_BORDER   = 3'd1;
    localparam logic [2:0] REG_FIRST_LINE    = 3'd2;
    localparam logic [2:0] REG_TIME_SHIFT    = 3'd3;
    localparam logic [2:0] REG_OFFSET_PAT    = 3'd4;
    localparam logic [2:0] REG_PATTERN_SEL   = 3'd5;
    localparam logic [2:0] REG_CONT_SEGMENTS = 3'd6;
    localparam logic [2:0] REG_MODE_FLAGS    = 3'd7;

    // Palette ports that count as ULA ports when enabled.
    localparam logic [15:0] PORT_PAL_SEL  = 16'hBF3B;
    localparam logic [15:0] PORT_PAL_DATA = 16'hFF3B;

    // Contention patterns; entry i of the 8 T-state group sits in bits [3i+2:3i].
    localparam logic [23:0] PAT_A = {3'd6, 3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
    localparam logic [23:0] PAT_B = {3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};

    typedef struct packed {
        logic [7:0] line_tstates;
        logic [5:0] left_border;
        logic [6:0] first_line;
        logic [3:0] time_shift;
        logic [3:0] offset_pat;
        logic [1:0] pattern_sel;
        logic [3:0] cont_segments;
        logic [2:0] mode_flags;
    } cfg_t;

    function automatic logic [2:0] pat_value(input logic alt, input logic [2:0] idx);
        logic [2:0] v;
        v = alt ? PAT_B[3*idx +: 3] : PAT_A[3*idx +: 3];
        return v;
    endfunction

endpackage

FILE: sv/ulamct_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing but the clock and reset.
module ulamct_div #(
    parameter int N = 19
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [7:0]   divisor,
    output logic         done,
    output logic [N-1:0] quotient,
    output logic [7:0]   remainder
);
    localparam int CW = $clog2(N + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]  rq_reg, rq_next;
    logic [7:0]    rem_reg, rem_next;
    logic [7:0]    dvs_reg, dvs_next;
    logic [8:0]    trial;
    logic [8:0]    diff;
    logic          ge;

    // The dividend leaves at the top of rq while quotient bits enter at the bottom.
    always_comb
    begin
        trial     = {rem_reg, rq_reg[N-1]};
        diff      = trial - {1'b0, dvs_reg};
        ge        = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rq_next   = rq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(N - 1);
            rq_next   = dividend;
            rem_next  = 8'd0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rq_next  = {rq_reg[N-2:0], ge};
            rem_next = ge ? diff[7:0] : trial[7:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg  <= rq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = rq_reg;
    assign remainder = rem_reg;
endmodule

FILE: sv/ulamct_lookup.sv
`timescale 1ns / 1ps
// Contention delay lookup for one counter value: line/position split and pattern.
// Depends on ulamct_pkg and ulamct_div.
module ulamct_lookup
    import ulamct_pkg::*;
#(
    parameter int COUNTER_BITS    = 18,
    parameter int DISPLAY_LINES   = 192,
    parameter int DISPLAY_TSTATES = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    io,
    input  logic [COUNTER_BITS-1:0] tval,
    input  cfg_t                    cfg,
    output logic                    done,
    output logic [2:0]              delay
);
    localparam int TW = COUNTER_BITS + 2;
    localparam int N  = COUNTER_BITS + 1;

    logic [TW-1:0] time_w;
    logic          quick;
    logic          div_start;
    logic          div_done;
    logic [N-1:0]  line;
    logic [7:0]    pos;
    logic [N-1:0]  line_lo, line_hi;
    logic [8:0]    pos_lo, pos_hi;
    logic          hit;
    logic [2:0]    idx;
    logic          done_reg;
    logic [2:0]    delay_reg, delay_next;

    always_comb
    begin
        time_w = TW'(tval) + TW'(cfg.left_border)
               + {{(TW-4){cfg.time_shift[3]}}, cfg.time_shift};
        // Negative time, no pattern, an empty line or disabled port contention: zero.
        quick = (io && cfg.mode_flags[2]) || cfg.pattern_sel[1]
              || (cfg.line_tstates == 8'd0) || time_w[TW-1];
        div_start = start && !quick;
    end

    ulamct_div #(.N(N)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (time_w[N-1:0]),
        .divisor   (cfg.line_tstates),
        .done      (div_done),
        .quotient  (line),
        .remainder (pos)
    );

    always_comb
    begin
        line_lo = N'(cfg.first_line);
        line_hi = N'(cfg.first_line) + N'(DISPLAY_LINES);
        pos_lo  = {3'd0, cfg.left_border};
        pos_hi  = {3'd0, cfg.left_border} + 9'(DISPLAY_TSTATES);
        hit = (line >= line_lo) && (line < line_hi)
           && ({1'b0, pos} >= pos_lo) && ({1'b0, pos} < pos_hi);
        idx = pos[2:0] + cfg.offset_pat[2:0];
        delay_next = delay_reg;
        if (start && quick)
            delay_next = 3'd0;
        else if (div_done)
            delay_next = hit ? pat_value(cfg.pattern_sel[0], idx) : 3'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (start && quick) || div_done;
    end

    always_ff @(posedge clk)
    begin
        delay_reg <= delay_next;
    end

    assign done  = done_reg;
    assign delay = delay_reg;
endmodule

FILE: sv/ula_memory_contention_timer_unit.sv
`timescale 1ns / 1ps
// ULA memory contention timer: T-state counter, item sequencer and output register.
// Depends on ulamct_pkg and ulamct_lookup.
//
// Input words arrive on s_tvalid/s_tready/s_tdata with the action on s_tuser.
// Each word gives one result word on m_tvalid/m_tready/m_tdata: the counter
// after the item and the contention T-states it inserted.
// Configuration registers are written over cfg_valid/cfg_ready/cfg_index/
// cfg_data; cfg_ready is always high. The user must write them only while the
// block is idle; the block itself does not enforce this.
// Loads and uncontended accesses pass from ST_IDLE through ST_FIN into the
// output register, after which the next input word can be taken. Each
// contention lookup runs a bit-serial division, one quotient bit per cycle;
// a contended memory access or early port phase, or a late phase on a ULA
// port, needs one lookup, and a late phase on a non-ULA port in contended
// space needs three.
// One word is worked on at a time; the next is taken as soon as the previous
// result has moved into the output register, even if it is not yet taken.
// When the receiver stalls, the finished result waits in the sequencer until
// the output register frees up. Reset clears the counter, loads the default
// configuration and empties the output register.
module ula_memory_contention_timer_unit
    import ulamct_pkg::*;
#(
    parameter int DISPLAY_LINES   = 192,
    parameter int DISPLAY_TSTATES = 128,
    parameter int COUNTER_BITS    = 18
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[15:0], base_tstates[19:16], load_value[37:20]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // tstate[17:0], delay[22:18]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int CB = COUNTER_BITS;
    localparam int WB = (CB > 18) ? CB : 18;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    cfg_t          cfg_reg;
    logic [1:0]    st_reg, st_next;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic [4:0]    tot_reg, tot_next;
    logic [1:0]    act_reg, act_next;
    logic          ula_reg, ula_next;
    logic [3:0]    base_reg, base_next;
    logic [1:0]    step_reg, step_next;
    logic          start_reg, start_next;
    logic          mv_reg, mv_next;
    logic [23:0]   md_reg, md_next;

    logic [15:0]   in_addr;
    logic [3:0]    in_base;
    logic [WB-1:0] load_ext;
    logic [WB-1:0] cnt_ext;
    logic          seg_hit;
    logic          port_ula;
    logic [4:0]    inc;
    logic          look_done;
    logic [2:0]    look_delay;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_tstates  <= 8'd224;
            cfg_reg.left_border   <= 6'd24;
            cfg_reg.first_line    <= 7'd64;
            cfg_reg.time_shift    <= 4'd1;
            cfg_reg.offset_pat    <= 4'hF;
            cfg_reg.pattern_sel   <= 2'd0;
            cfg_reg.cont_segments <= 4'd2;
            cfg_reg.mode_flags    <= 3'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LINE_TSTATES:  cfg_reg.line_tstates  <= cfg_data;
                REG_LEFT_BORDER:   cfg_reg.left_border   <= cfg_data[5:0];
                REG_FIRST_LINE:    cfg_reg.first_line    <= cfg_data[6:0];
                REG_TIME_SHIFT:    cfg_reg.time_shift    <= cfg_data[3:0];
                REG_OFFSET_PAT:    cfg_reg.offset_pat    <= cfg_data[3:0];
                REG_PATTERN_SEL:   cfg_reg.pattern_sel   <= cfg_data[1:0];
                REG_CONT_SEGMENTS: cfg_reg.cont_segments <= cfg_data[3:0];
                REG_MODE_FLAGS:    cfg_reg.mode_flags    <= cfg_data[2:0];
            endcase
        end
    end

    ulamct_lookup #(
        .COUNTER_BITS    (CB),
        .DISPLAY_LINES   (DISPLAY_LINES),
        .DISPLAY_TSTATES (DISPLAY_TSTATES)
    ) u_lookup (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .io    (act_reg != ACT_MEM),
        .tval  (cnt_reg),
        .cfg   (cfg_reg),
        .done  (look_done),
        .delay (look_delay)
    );

    assign s_tready = (st_reg == ST_IDLE);

    always_comb
    begin
        in_addr  = s_tdata[15:0];
        in_base  = s_tdata[19:16];
        load_ext = WB'(s_tdata[37:20]);
        cnt_ext  = WB'(cnt_reg);
        seg_hit  = cfg_reg.cont_segments[in_addr[15:14]];
        port_ula = (cfg_reg.mode_flags[1]
                    && (in_addr == PORT_PAL_SEL || in_addr == PORT_PAL_DATA))
                || (cfg_reg.mode_flags[0] && !in_addr[0]);

        st_next    = st_reg;
        cnt_next   = cnt_reg;
        tot_next   = tot_reg;
        act_next   = act_reg;
        ula_next   = ula_reg;
        base_next  = base_reg;
        step_next  = step_reg;
        start_next = 1'b0;
        inc        = 5'd0;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next  = s_tuser;
                    ula_next  = port_ula;
                    base_next = in_base;
                    step_next = 2'd0;
                    tot_next  = 5'd0;
                    st_next   = ST_FIN;
                    unique case (s_tuser)
                        ACT_MEM:
                        begin
                            if (seg_hit)
                                st_next = ST_WAIT;
                            else
                                inc = {1'b0, in_base};
                        end
                        ACT_EARLY:
                        begin
                            if (seg_hit)
                                st_next = ST_WAIT;
                            else
                                inc = 5'd1;
                        end
                        ACT_LATE:
                        begin
                            if (port_ula || seg_hit)
                                st_next = ST_WAIT;
                            else
                                inc = 5'd2;
                        end
                        ACT_LOAD:
                        begin
                            inc = 5'd0;
                        end
                    endcase
                    start_next = (st_next == ST_WAIT);
                    if (s_tuser == ACT_LOAD)
                        cnt_next = load_ext[CB-1:0];
                    else
                        cnt_next = cnt_reg + CB'(inc);
                end
            end
            ST_WAIT:
            begin
                if (look_done)
                begin
                    tot_next = tot_reg + 5'(look_delay);
                    st_next  = ST_FIN;
                    priority if (act_reg == ACT_MEM)
                        inc = 5'(look_delay) + 5'(base_reg);
                    else if (act_reg == ACT_EARLY)
                        inc = 5'(look_delay) + 5'd1;
                    else if (ula_reg)
                        inc = 5'(look_delay) + 5'd2;
                    else if (step_reg != 2'd2)
                    begin
                        // Three lookups, one T-state apart, on a non-ULA contended port.
                        inc        = 5'(look_delay) + 5'd1;
                        step_next  = step_reg + 2'd1;
                        start_next = 1'b1;
                        st_next    = ST_WAIT;
                    end
                    else
                        inc = 5'(look_delay);
                    cnt_next = cnt_reg + CB'(inc);
                end
            end
            ST_FIN:
            begin
                if (!mv_reg || m_tready)
                begin
                    mv_next = 1'b1;
                    md_next = {1'b0, tot_reg, cnt_ext[17:0]};
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            cnt_reg   <= '0;
            start_reg <= 1'b0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            cnt_reg   <= cnt_next;
            start_reg <= start_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tot_reg  <= tot_next;
        act_reg  <= act_next;
        ula_reg  <= ula_next;
        base_reg <= base_next;
        step_reg <= step_next;
        md_reg   <= md_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for ula_memory_contention_timer_unit: streams memory, port and load words
// through the block and compares each result word with a local timing predictor.
// Depends on ulamct_pkg and the block's RTL.
module tb;
    import ulamct_pkg::*;

    typedef struct packed {
        logic [17:0] tstate;
        logic [4:0]  delay;
    } timing_t;

    typedef enum {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;

    localparam int HOLD_CYCLES = 400;

    // Keeps its own copy of the registers and the T-state counter, and the
    // timings still owed by the block in arrival order.
    class contention_board;
        localparam int SCREEN_LINES   = 192;
        localparam int SCREEN_TSTATES = 128;

        cfg_t        cfg;
        logic [17:0] counter;
        timing_t     owed[$];
        int unsigned mismatches;
        int unsigned checked;
        int unsigned hot_results;
        int unsigned per_action[4];

        function new();
            cfg.line_tstates  = 8'd224;
            cfg.left_border   = 6'd24;
            cfg.first_line    = 7'd64;
            cfg.time_shift    = 4'd1;
            cfg.offset_pat    = 4'hF;
            cfg.pattern_sel   = 2'd0;
            cfg.cont_segments = 4'd2;
            cfg.mode_flags    = 3'd1;
            counter = '0;
        endfunction

        static function int sext4(logic [3:0] v);
            return v[3] ? int'(v) - 16 : int'(v);
        endfunction

        static function int unsigned pattern_step(logic alt, logic [2:0] idx);
            case (idx)
                3'd0: return 5;
                3'd1: return 4;
                3'd2: return 3;
                3'd3: return 2;
                3'd4: return 1;
                3'd5: return 0;
                3'd6: return alt ? 7 : 0;
                default: return 6;
            endcase
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] v);
            case (idx)
                REG_LINE_TSTATES:  cfg.line_tstates  = v;
                REG_LEFT_BORDER:   cfg.left_border   = v[5:0];
                REG_FIRST_LINE:    cfg.first_line    = v[6:0];
                REG_TIME_SHIFT:    cfg.time_shift    = v[3:0];
                REG_OFFSET_PAT:    cfg.offset_pat    = v[3:0];
                REG_PATTERN_SEL:   cfg.pattern_sel   = v[1:0];
                REG_CONT_SEGMENTS: cfg.cont_segments = v[3:0];
                REG_MODE_FLAGS:    cfg.mode_flags    = v[2:0];
                default: ;
            endcase
        endfunction

        // Contention T-states at counter value t; the port view is silenced
        // when port contention is switched off.
        function int unsigned contention_at(logic [17:0] t, bit port_view);
            int lt;
            int lb;
            int tm;
            int line_no;
            int pos;
            int idx;
            if (port_view && cfg.mode_flags[2])
                return 0;
            if (cfg.pattern_sel > 2'd1 || cfg.line_tstates == 8'd0)
                return 0;
            lt = int'(cfg.line_tstates);
            lb = int'(cfg.left_border);
            tm = int'(t) + lb + sext4(cfg.time_shift);
            if (tm < 0)
                return 0;
            line_no = tm / lt;
            pos = tm % lt;
            if (line_no < int'(cfg.first_line) || line_no >= int'(cfg.first_line) + SCREEN_LINES)
                return 0;
            if (pos < lb || pos >= lb + SCREEN_TSTATES)
                return 0;
            idx = pos + sext4(cfg.offset_pat);
            return pattern_step(cfg.pattern_sel[0], idx[2:0]);
        endfunction

        function void predict_word(logic [1:0] act, logic [15:0] addr, logic [3:0] base,
                                   logic [17:0] load);
            logic [17:0] t;
            int unsigned d;
            int unsigned total;
            bit          seg_hot;
            bit          ula_port;
            timing_t     rec;
            int          k;
            t = counter;
            total = 0;
            seg_hot = cfg.cont_segments[addr[15:14]];
            ula_port = (cfg.mode_flags[1] && (addr == PORT_PAL_SEL || addr == PORT_PAL_DATA))
                       || (cfg.mode_flags[0] && !addr[0]);
            case (act)
                ACT_MEM:
                begin
                    if (seg_hot)
                    begin
                        d = contention_at(t, 1'b0);
                        total += d;
                        t += 18'(d);
                    end
                    t += 18'(base);
                end
                ACT_EARLY:
                begin
                    if (seg_hot)
                    begin
                        d = contention_at(t, 1'b1);
                        total += d;
                        t += 18'(d);
                    end
                    t += 18'd1;
                end
                ACT_LATE:
                begin
                    if (ula_port)
                    begin
                        d = contention_at(t, 1'b1);
                        total += d;
                        t += 18'(d + 2);
                    end
                    else if (seg_hot)
                    begin
                        // A foreign port in contended space is held three times.
                        for (k = 0; k < 3; k++)
                        begin
                            d = contention_at(t, 1'b1);
                            total += d;
                            t += 18'(d);
                            if (k < 2)
                                t += 18'd1;
                        end
                    end
                    else
                        t += 18'd2;
                end
                ACT_LOAD:
                    t = load;
            endcase
            counter = t;
            rec.tstate = t;
            rec.delay = 5'(total);
            owed.push_back(rec);
            per_action[act]++;
            if (total != 0)
                hot_results++;
        endfunction

        function void check_word(logic [17:0] tstate, logic [4:0] delay);
            timing_t want;
            checked++;
            if (owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: word %0d arrived with nothing owed (tstate=%0d delay=%0d)",
                             checked, tstate, delay);
                return;
            end
            want = owed.pop_front();
            if (want.tstate !== tstate || want.delay !== delay)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: word %0d: tstate exp %0d got %0d, delay exp %0d got %0d",
                             checked, want.tstate, tstate, want.delay, delay);
            end
        endfunction

        function void close_out();
            if (owed.size() != 0)
            begin
                $display("ERROR: %0d result words never arrived", owed.size());
                mismatches += owed.size();
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // address[15:0], base_tstates[19:16], load_value[37:20]
    logic [1:0]  s_tuser = ACT_MEM;   // action[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // tstate[17:0], delay[22:18]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_LINE_TSTATES;
    logic [7:0]  cfg_data = '0;

    contention_board sb = new();
    pace_t       pace = PACE_RX_SLOW;
    int unsigned hold_asks = 0;
    int unsigned hold_done = 0;
    int unsigned hold_left = 0;
    int unsigned settings_written = 0;

    ula_memory_contention_timer_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_500_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random ready, or a long hold-off when the stimulus asks for one.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_done)
        begin
            hold_done <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            case (pace)
                PACE_RX_SLOW: m_tready <= ($urandom_range(0, 99) >= 84);
                PACE_TX_SLOW: m_tready <= ($urandom_range(0, 99) >= 28);
                default:      m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata[17:0], m_tdata[22:18]);
    end

    function automatic bit tx_gap();
        case (pace)
            PACE_RX_SLOW: return $urandom_range(0, 99) < 28;
            PACE_TX_SLOW: return $urandom_range(0, 99) < 84;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic cfg_t make_setting(int lt, int lb, int fl, int ot, int op, int sel,
                                          int seg, int mode);
        cfg_t s;
        s.line_tstates  = 8'(lt);
        s.left_border   = 6'(lb);
        s.first_line    = 7'(fl);
        s.time_shift    = 4'(ot);
        s.offset_pat    = 4'(op);
        s.pattern_sel   = 2'(sel);
        s.cont_segments = 4'(seg);
        s.mode_flags    = 3'(mode);
        return s;
    endfunction

    function automatic cfg_t random_setting(bit any_bits);
        cfg_t        s;
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        if (any_bits)
            return raw[$bits(cfg_t)-1:0];
        s = make_setting($urandom_range(200, 255), $urandom_range(1, 63),
                         $urandom_range(0, 127), int'($urandom_range(0, 11)) - 4,
                         int'($urandom_range(0, 8)) - 1,
                         ($urandom_range(0, 9) == 0) ? 2 : $urandom_range(0, 1),
                         $urandom_range(0, 15), $urandom_range(0, 7));
        return s;
    endfunction

    // Counter value that puts the lookup at pixel column px of display line
    // line_idx under the current registers.
    function automatic logic [17:0] display_tstate(int line_idx, int px);
        int lt;
        int tm;
        lt = (sb.cfg.line_tstates == 8'd0) ? 224 : int'(sb.cfg.line_tstates);
        tm = (int'(sb.cfg.first_line) + line_idx) * lt + px
             - contention_board::sext4(sb.cfg.time_shift);
        return (tm < 0) ? 18'd0 : 18'(tm);
    endfunction

    task automatic send_word(input logic [1:0] act, input logic [15:0] addr,
                             input logic [3:0] base, input logic [17:0] load);
        while (tx_gap())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {2'b00, load, base, addr};
        do @(posedge clk); while (!s_tready);
        sb.predict_word(act, addr, base, load);
    endtask

    task automatic send_access(input logic [1:0] act, input logic [15:0] addr,
                               input logic [3:0] base);
        send_word(act, addr, base, 18'($urandom()));
    endtask

    task automatic send_load(input logic [17:0] value);
        send_word(ACT_LOAD, 16'($urandom()), 4'($urandom()), value);
    endtask

    // Waits until every owed result word has been taken.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.owed.size() != 0);
    endtask

    // Writes all eight registers; unused upper data bits carry random noise.
    task automatic program_setting(input cfg_t s);
        logic [2:0] regs [8];
        logic [7:0] vals [8];
        logic [7:0] keep [8];
        logic [7:0] word;
        int         i;
        regs = '{REG_LINE_TSTATES, REG_LEFT_BORDER, REG_FIRST_LINE, REG_TIME_SHIFT,
                 REG_OFFSET_PAT, REG_PATTERN_SEL, REG_CONT_SEGMENTS, REG_MODE_FLAGS};
        vals = '{s.line_tstates, 8'(s.left_border), 8'(s.first_line), 8'(s.time_shift),
                 8'(s.offset_pat), 8'(s.pattern_sel), 8'(s.cont_segments), 8'(s.mode_flags)};
        keep = '{8'hFF, 8'h3F, 8'h7F, 8'h0F, 8'h0F, 8'h03, 8'h0F, 8'h07};
        for (i = 0; i < 8; i++)
        begin
            word = (8'($urandom()) & ~keep[i]) | (vals[i] & keep[i]);
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= word;
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(regs[i], word);
        end
        cfg_valid <= 1'b0;
        settings_written++;
    endtask

    task automatic random_access();
        logic [1:0]  act;
        logic [15:0] addr;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        act = (pick < 5) ? ACT_MEM : (pick < 7) ? ACT_EARLY : ACT_LATE;
        addr = 16'($urandom());
        if (act == ACT_LATE)
        begin
            case ($urandom_range(0, 5))
                0: addr = PORT_PAL_SEL;
                1: addr = PORT_PAL_DATA;
                2: addr[0] = 1'b0;
                3: addr[0] = 1'b1;
                default: ;
            endcase
        end
        send_access(act, addr, 4'($urandom()));
    endtask

    // Mostly a load into or near the screen area followed by a short run of
    // accesses; the rest is unrelated noise and counter wrap cases.
    task automatic run_phase(input int unsigned quota);
        int unsigned sent;
        int unsigned burst;
        int          lt;
        int          line_idx;
        int          px;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                case ($urandom_range(0, 2))
                    0: send_load(18'($urandom()));
                    1: send_load(18'h3FFFF - 18'($urandom_range(0, 20)));
                    default: send_word(2'($urandom()), 16'($urandom()), 4'($urandom()),
                                       18'($urandom()));
                endcase
                sent++;
            end
            else
            begin
                lt = (sb.cfg.line_tstates == 8'd0) ? 224 : int'(sb.cfg.line_tstates);
                line_idx = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 195)) - 2
                                                         : int'($urandom_range(0, 191));
                px = ($urandom_range(0, 4) == 0)
                     ? int'($urandom_range(0, lt - 1)) - int'(sb.cfg.left_border)
                     : int'($urandom_range(0, 127));
                send_load(display_tstate(line_idx, px));
                sent++;
                burst = $urandom_range(2, 8);
                repeat (burst)
                begin
                    random_access();
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        int unsigned ph;
        cfg_t        s;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers as left by reset.
        send_load(18'd0);
        send_access(ACT_MEM, 16'h4000, 4'd15);
        send_load(display_tstate(0, 0));
        send_access(ACT_MEM, 16'h7FFF, 4'd0);
        send_access(ACT_EARLY, 16'h40FE, 4'd0);
        send_access(ACT_LATE, 16'h80FE, 4'd0);
        send_access(ACT_LATE, 16'h7FFD, 4'd0);
        send_access(ACT_LATE, 16'h00FF, 4'd0);
        send_access(ACT_LATE, PORT_PAL_SEL, 4'd0);
        send_access(ACT_MEM, 16'hC000, 4'd7);
        send_load(18'h3FFFF);
        send_access(ACT_MEM, 16'hFFFF, 4'd15);
        send_load(display_tstate(191, 127));
        send_access(ACT_MEM, 16'h4000, 4'd3);

        // Palette ports on, port contention off, second pattern.
        settle();
        program_setting(make_setting(224, 24, 64, 1, -1, 1, 15, 7));
        send_load(display_tstate(10, 6));
        send_access(ACT_LATE, PORT_PAL_DATA, 4'd0);
        send_access(ACT_EARLY, 16'h4001, 4'd0);
        send_access(ACT_MEM, 16'h0000, 4'd0);

        // Time below zero and a pattern offset that makes the index negative.
        settle();
        program_setting(make_setting(200, 1, 0, -8, -8, 1, 15, 2));
        send_load(18'd0);
        send_access(ACT_MEM, 16'h1234, 4'd1);
        send_load(18'd8);
        send_access(ACT_MEM, 16'h2000, 4'd2);

        // Zero line length, then the unused pattern select code.
        settle();
        program_setting(make_setting(0, 1, 0, -8, -8, 1, 15, 2));
        send_access(ACT_MEM, 16'h3000, 4'd0);
        settle();
        program_setting(make_setting(200, 1, 0, -8, -8, 3, 15, 2));
        send_access(ACT_MEM, 16'h3000, 4'd0);

        for (ph = 0; ph < 7; ph++)
        begin
            settle();
            case (ph)
                1: s = make_setting(200, 1, 0, -4, -1, 1, 15, 0);
                2: s = make_setting(255, 63, 127, 7, 7, 0, 15, 3);
                3:
                begin
                    s = random_setting(1'b0);
                    s.pattern_sel = 2'd2;
                    s.cont_segments = 4'd0;
                    s.mode_flags = 3'd7;
                end
                5: s = random_setting(1'b1);
                default: s = random_setting(1'b0);
            endcase
            program_setting(s);
            pace = (ph < 2) ? PACE_RX_SLOW : (ph < 4) ? PACE_TX_SLOW : PACE_FULL;
            if (ph == 4)
                hold_asks++;
            run_phase(100);
        end

        settle();
        repeat (100) @(posedge clk);
        sb.close_out();
        $display("Covered %0d memory, %0d early, %0d late and %0d load words, %0d settings.",
                 sb.per_action[ACT_MEM], sb.per_action[ACT_EARLY], sb.per_action[ACT_LATE],
                 sb.per_action[ACT_LOAD], settings_written);
        $display("Checked %0d result words, %0d of them contended; %0d mismatches.",
                 sb.checked, sb.hot_results, sb.mismatches);
        if (sb.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/ulamct_pkg.sv
sv/ulamct_div.sv
sv/ulamct_lookup.sv
sv/ula_memory_contention_timer_unit.sv
tb/tb.sv
